[rtl/core/kpsd_pkg.sv]
// Shared types, constants and the seven-segment table for the keypad scanner
// with multiplexed display. Has no dependencies; every file but kpsd_checker imports it.
`timescale 1ns / 1ps

package kpsd_pkg;

  localparam int unsigned KeyRows       = 4;
  localparam int unsigned DisplayDigits = 3;
  localparam int unsigned QueueDepth    = 2;

  localparam logic [9:0] DebounceReset  = 10'd10;
  localparam logic [9:0] DigitHoldReset = 10'd5;

  localparam logic CfgDebounceTicks  = 1'b0;
  localparam logic CfgDigitHoldTicks = 1'b1;

  typedef enum logic [1:0] {
    PhaseIdle     = 2'd0,
    PhaseDebounce = 2'd1,
    PhaseRelease  = 2'd2
  } kpsd_phase_e;

  typedef struct packed {
    logic [1:0] row;
    logic [8:0] value;
    logic       key_event;
    logic [1:0] digit;
  } kpsd_entry_t;

  function automatic logic [6:0] kpsd_segments(input logic [3:0] digit);
    logic [6:0] seg;
    case (digit)
      4'd0:    seg = 7'h3f;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5b;
      4'd3:    seg = 7'h4f;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6d;
      4'd6:    seg = 7'h7d;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7f;
      4'd9:    seg = 7'h6f;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

[rtl/core/keypad_scan_to_segment_display.sv]
// Top level of the 4x4 keypad scanner with three-digit multiplexed display.
// Instantiates kpsd_front, kpsd_fifo and kpsd_back; depends on kpsd_pkg.
//
// Each request on the input channel is one tick carrying the keypad column
// lines for the row named by the previous result's row_drive; each tick
// yields exactly one result request with the row drive, digit enable,
// segment pattern, latched value (key number squared) and a key event flag.
// The block takes one tick per clock cycle while the queue has space: the
// scan state machine updates on each accepted tick, and a two-entry queue
// decouples it from the digit split and segment encode, which feed the
// output register. Configuration writes to debounce_ticks (index 0) and
// digit_hold_ticks (index 1) take effect on the next tick; zero acts as one.
`timescale 1ns / 1ps

module keypad_scan_to_segment_display (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [9:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [3:0] column_sense_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] row_drive_o,
  output logic [2:0] digit_select_o,
  output logic [6:0] segment_pattern_o,
  output logic [8:0] key_value_o,
  output logic       key_event_o
);
  import kpsd_pkg::*;

  logic        push, space, head_valid, pop;
  kpsd_entry_t entry, head;

  assign in_ready_o = space;

  kpsd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .space_i        (space),
    .column_sense_i (column_sense_i),
    .push_o         (push),
    .entry_o        (entry)
  );

  kpsd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .space_o      (space),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_o       (head)
  );

  kpsd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_valid_i      (head_valid),
    .head_i            (head),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .row_drive_o       (row_drive_o),
    .digit_select_o    (digit_select_o),
    .segment_pattern_o (segment_pattern_o),
    .key_value_o       (key_value_o),
    .key_event_o       (key_event_o)
  );

endmodule

[rtl/core/kpsd_front.sv]
// Front part: configuration registers, keypad scan state machine and display
// timing. Computes the state after each accepted tick. Depends on kpsd_pkg.
`timescale 1ns / 1ps

module kpsd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [9:0]           cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 space_i,
  input  logic [3:0]           column_sense_i,
  output logic                 push_o,
  output kpsd_pkg::kpsd_entry_t entry_o
);
  import kpsd_pkg::*;

  logic [9:0]  debounce_q, hold_q;
  kpsd_phase_e phase_q, phase_d;
  logic [1:0]  row_q, row_d, row_next;
  logic [9:0]  count_q, count_d, count_inc, need;
  logic [8:0]  value_q, value_d;
  logic [1:0]  digit_q, digit_d, digit_cur;
  logic [9:0]  timer_q, timer_d, hold;
  logic        accept, pressed, count_done, col_hit, key_event;
  logic [1:0]  col;
  logic [4:0]  key_num;
  logic [9:0]  key_sq;

  assign accept  = in_valid_i && space_i;
  assign pressed = (column_sense_i != 4'hF);

  always_comb begin
    col_hit = 1'b1;
    case (column_sense_i)
      4'hE:    col = 2'd0;
      4'hD:    col = 2'd1;
      4'hB:    col = 2'd2;
      4'h7:    col = 2'd3;
      default: begin
        col     = 2'd0;
        col_hit = 1'b0;
      end
    endcase
  end

  assign row_next   = (({1'b0, row_q} + 3'd1) >= 3'(KeyRows)) ? 2'd0 : row_q + 2'd1;
  assign count_inc  = (count_q == 10'h3FF) ? count_q : count_q + 10'd1;
  assign need       = (debounce_q == 10'd0) ? 10'd1 : debounce_q;
  assign count_done = (count_inc >= need);
  assign key_num    = {1'b0, row_q, col} + 5'd1;
  assign key_sq     = {5'd0, key_num} * {5'd0, key_num};

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PhaseDebounce: begin
        if (!pressed) begin
          phase_d = PhaseIdle;
        end else if (count_done) begin
          phase_d = PhaseRelease;
        end
      end
      PhaseRelease: begin
        if (!pressed) begin
          phase_d = PhaseIdle;
        end
      end
      default: begin
        phase_d = pressed ? PhaseDebounce : PhaseIdle;
      end
    endcase
  end

  always_comb begin
    row_d     = row_q;
    count_d   = count_q;
    value_d   = value_q;
    key_event = 1'b0;
    case (phase_q)
      PhaseDebounce: begin
        if (!pressed) begin
          count_d = 10'd0;
          row_d   = row_next;
        end else if (count_done) begin
          count_d = 10'd0;
          if (col_hit) begin
            value_d   = key_sq[8:0];
            key_event = 1'b1;
          end
        end else begin
          count_d = count_inc;
        end
      end
      PhaseRelease: begin
        if (!pressed) begin
          row_d = row_next;
        end
      end
      default: begin
        if (pressed) begin
          count_d = 10'd0;
        end else begin
          row_d = row_next;
        end
      end
    endcase
  end

  assign hold      = (hold_q == 10'd0) ? 10'd1 : hold_q;
  assign digit_cur = ({1'b0, digit_q} >= 3'(DisplayDigits)) ? 2'd0 : digit_q;

  always_comb begin
    if (({1'b0, timer_q} + 11'd1) >= {1'b0, hold}) begin
      timer_d = 10'd0;
      digit_d = (({1'b0, digit_cur} + 3'd1) >= 3'(DisplayDigits)) ? 2'd0 : digit_cur + 2'd1;
    end else begin
      timer_d = timer_q + 10'd1;
      digit_d = digit_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceReset;
      hold_q     <= DigitHoldReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgDebounceTicks) begin
        debounce_q <= cfg_data_i;
      end else begin
        hold_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseIdle;
      row_q   <= 2'd0;
      count_q <= 10'd0;
      value_q <= 9'd0;
      digit_q <= 2'd0;
      timer_q <= 10'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      row_q   <= row_d;
      count_q <= count_d;
      value_q <= value_d;
      digit_q <= digit_d;
      timer_q <= timer_d;
    end
  end

  assign push_o            = accept;
  assign entry_o.row       = row_d;
  assign entry_o.value     = value_d;
  assign entry_o.key_event = key_event;
  assign entry_o.digit     = digit_d;

endmodule

[rtl/core/kpsd_fifo.sv]
// Short queue between the scan front and the display back.
// Holds per-tick state snapshots. Depends on kpsd_pkg.
`timescale 1ns / 1ps

module kpsd_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  kpsd_pkg::kpsd_entry_t entry_i,
  output logic                  space_o,
  output logic                  head_valid_o,
  input  logic                  pop_i,
  output kpsd_pkg::kpsd_entry_t head_o
);
  import kpsd_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  kpsd_entry_t         slots_q [QueueDepth];
  logic [PtrW-1:0]     wptr_q, rptr_q;
  logic [CntW-1:0]     count_q;

  assign space_o      = (count_q != CntW'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = slots_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

[rtl/core/kpsd_back.sv]
// Back part: splits the latched value into decimal digits, picks the lit one,
// encodes segments and holds the result register. Depends on kpsd_pkg.
`timescale 1ns / 1ps

module kpsd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  kpsd_pkg::kpsd_entry_t head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [3:0]            row_drive_o,
  output logic [2:0]            digit_select_o,
  output logic [6:0]            segment_pattern_o,
  output logic [8:0]            key_value_o,
  output logic                  key_event_o
);
  import kpsd_pkg::*;

  logic        out_valid_q;
  logic [3:0]  row_drive_q;
  logic [2:0]  digit_select_q;
  logic [6:0]  segment_q;
  logic [8:0]  value_q;
  logic        event_q;
  logic [3:0]  hundreds, tens, units, digit;
  logic [8:0]  rem_wide;
  logic [6:0]  rem;
  logic [14:0] tens_prod;
  logic [7:0]  tens_times_ten;

  assign pop_o = head_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    if (head_i.value >= 9'd200) begin
      hundreds = 4'd2;
      rem_wide = head_i.value - 9'd200;
    end else if (head_i.value >= 9'd100) begin
      hundreds = 4'd1;
      rem_wide = head_i.value - 9'd100;
    end else begin
      hundreds = 4'd0;
      rem_wide = head_i.value;
    end
  end

  assign rem            = rem_wide[6:0];
  assign tens_prod      = {8'd0, rem} * 15'd205;
  assign tens           = tens_prod[14:11];
  assign tens_times_ten = {4'd0, tens} * 8'd10;
  assign units          = 4'(({1'b0, rem} - tens_times_ten));

  always_comb begin
    case (head_i.digit)
      2'd0:    digit = hundreds;
      2'd1:    digit = tens;
      default: digit = units;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      row_drive_q    <= ~(4'b0001 << head_i.row);
      digit_select_q <= ~(3'b001 << head_i.digit);
      segment_q      <= kpsd_segments(digit);
      value_q        <= head_i.value;
      event_q        <= head_i.key_event;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign row_drive_o       = row_drive_q;
  assign digit_select_o    = digit_select_q;
  assign segment_pattern_o = segment_q;
  assign key_value_o       = value_q;
  assign key_event_o       = event_q;

endmodule

[rtl/core/kpsd_checker.sv]
// Port-level checks for the keypad scanner top level, attached by bind.
// Sees only the top-level ports; no package dependency.
`timescale 1ns / 1ps

module kpsd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [3:0] row_drive_o,
  input logic [2:0] digit_select_o,
  input logic [6:0] segment_pattern_o,
  input logic [8:0] key_value_o,
  input logic       key_event_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(key_value_o)
      && $stable(segment_pattern_o) && $stable(row_drive_o))
    else $error("Stalled result changed.");

  a_one_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones(~row_drive_o) == 1)
    else $error("Row drive does not have exactly one low row.");

  a_one_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones(~digit_select_o) == 1)
    else $error("Digit select does not have exactly one low digit.");

  a_event_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_event_o |-> key_value_o != 9'd0)
    else $error("Key event with zero value.");

  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> key_value_o <= 9'd256)
    else $error("Latched value out of range.");

endmodule

bind keypad_scan_to_segment_display kpsd_checker u_kpsd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .row_drive_o       (row_drive_o),
  .digit_select_o    (digit_select_o),
  .segment_pattern_o (segment_pattern_o),
  .key_value_o       (key_value_o),
  .key_event_o       (key_event_o)
);

[test/keypad_display_checker.sv]
// Checker for the keypad scanner with multiplexed display: predicts one display
// frame per accepted tick request and compares it with each accepted result.
// Depends on kpsd_pkg for the phase type, register indexes and reset values.
`timescale 1ns / 1ps

module keypad_display_checker
  import kpsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [9:0] cfg_data_i,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [3:0] column_sense_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [3:0] row_drive_i,
  input  logic [2:0] digit_select_i,
  input  logic [6:0] segment_pattern_i,
  input  logic [8:0] key_value_i,
  input  logic       key_event_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic [3:0] row_drive;
    logic [2:0] digit_select;
    logic [6:0] segment_pattern;
    logic [8:0] key_value;
    logic       key_event;
  } display_frame_t;

  localparam logic [69:0] DigitGlyphs = {
    7'h6f, 7'h7f, 7'h07, 7'h7d, 7'h6d, 7'h66, 7'h4f, 7'h5b, 7'h06, 7'h3f
  };

  logic [9:0]     debounce_ticks;
  logic [9:0]     digit_hold_ticks;
  logic [1:0]     active_row;
  kpsd_phase_e    scan_phase;
  logic [9:0]     debounce_count;
  logic [8:0]     latched_value;
  logic [1:0]     digit_index;
  logic [9:0]     digit_timer;
  display_frame_t expected_frames[$];
  int             mismatches;

  task automatic step_row();
    active_row = (int'(active_row) + 1 >= KeyRows) ? 2'd0 : active_row + 2'd1;
  endtask

  task automatic predict_tick(input logic [3:0] cols, output display_frame_t frame);
    logic        pressed;
    logic        hit;
    logic [9:0]  need;
    logic [9:0]  hold;
    int unsigned col;
    int unsigned key;
    int unsigned digit;
    pressed = (cols != 4'hF);
    frame.key_event = 1'b0;
    col = 0;
    case (scan_phase)
      PhaseDebounce: begin
        if (!pressed) begin
          scan_phase = PhaseIdle;
          debounce_count = '0;
          step_row();
        end else begin
          if (debounce_count != 10'h3FF) debounce_count = debounce_count + 10'd1;
          need = (debounce_ticks == '0) ? 10'd1 : debounce_ticks;
          if (debounce_count >= need) begin
            hit = 1'b1;
            case (cols)
              4'hE: col = 0;
              4'hD: col = 1;
              4'hB: col = 2;
              4'h7: col = 3;
              default: hit = 1'b0;
            endcase
            if (hit) begin
              key = int'(active_row) * 4 + col + 1;
              latched_value = 9'(key * key);
              frame.key_event = 1'b1;
            end
            scan_phase = PhaseRelease;
            debounce_count = '0;
          end
        end
      end
      PhaseRelease: begin
        if (!pressed) begin
          scan_phase = PhaseIdle;
          step_row();
        end
      end
      default: begin
        if (pressed) begin
          scan_phase = PhaseDebounce;
          debounce_count = '0;
        end else begin
          scan_phase = PhaseIdle;
          step_row();
        end
      end
    endcase

    hold = (digit_hold_ticks == '0) ? 10'd1 : digit_hold_ticks;
    if (digit_index >= DisplayDigits) digit_index = '0;
    if (int'(digit_timer) + 1 >= int'(hold)) begin
      digit_timer = '0;
      digit_index = (int'(digit_index) + 1 >= DisplayDigits) ? 2'd0 : digit_index + 2'd1;
    end else begin
      digit_timer = digit_timer + 10'd1;
    end

    case (digit_index)
      2'd0:    digit = (int'(latched_value) / 100) % 10;
      2'd1:    digit = (int'(latched_value) / 10) % 10;
      default: digit = int'(latched_value) % 10;
    endcase

    frame.row_drive       = ~(4'b0001 << active_row);
    frame.digit_select    = ~(3'b001 << digit_index);
    frame.segment_pattern = DigitGlyphs[digit * 7 +: 7];
    frame.key_value       = latched_value;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    display_frame_t frame;
    display_frame_t want;
    if (!rst_ni) begin
      debounce_ticks   = DebounceReset;
      digit_hold_ticks = DigitHoldReset;
      active_row       = '0;
      scan_phase       = PhaseIdle;
      debounce_count   = '0;
      latched_value    = '0;
      digit_index      = '0;
      digit_timer      = '0;
      mismatches       = 0;
      expected_frames.delete();
      fail_count_o    <= 0;
      pending_o       <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgDebounceTicks:  debounce_ticks = cfg_data_i;
          CfgDigitHoldTicks: digit_hold_ticks = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        predict_tick(column_sense_i, frame);
        expected_frames.push_back(frame);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_frames.size() == 0) begin
          $error("result request with no expected frame waiting");
          mismatches++;
        end else begin
          want = expected_frames.pop_front();
          check_field("row_drive", want.row_drive, row_drive_i);
          check_field("digit_select", want.digit_select, digit_select_i);
          check_field("segment_pattern", want.segment_pattern, segment_pattern_i);
          check_field("key_value", want.key_value, key_value_i);
          check_field("key_event", want.key_event, key_event_i);
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_frames.size();
    end
  end

endmodule

[test/tb_top.sv]
// Top of the keypad scanner testbench: clock, reset, register writes, tick
// stimulus and result back-pressure around keypad_scan_to_segment_display.
// Depends on kpsd_pkg and keypad_display_checker, which does the comparison.
`timescale 1ns / 1ps

module tb_top;
  import kpsd_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [9:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [3:0] column_sense;
  logic       out_valid;
  logic       out_ready;
  logic [3:0] row_drive;
  logic [2:0] digit_select;
  logic [6:0] segment_pattern;
  logic [8:0] key_value;
  logic       key_event;
  int         fail_count;
  int         pending;
  int         send_quiet;
  int         take_quiet;

  keypad_scan_to_segment_display DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .column_sense_i    (column_sense),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .row_drive_o       (row_drive),
    .digit_select_o    (digit_select),
    .segment_pattern_o (segment_pattern),
    .key_value_o       (key_value),
    .key_event_o       (key_event)
  );

  keypad_display_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .column_sense_i    (column_sense),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .row_drive_i       (row_drive),
    .digit_select_i    (digit_select),
    .segment_pattern_i (segment_pattern),
    .key_value_i       (key_value),
    .key_event_i       (key_event),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  task automatic set_config(input logic [9:0] debounce, input logic [9:0] hold);
    cfg_we    <= 1'b1;
    cfg_index <= CfgDebounceTicks;
    cfg_data  <= debounce;
    @(posedge clk);
    cfg_index <= CfgDigitHoldTicks;
    cfg_data  <= hold;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_tick(input logic [3:0] cols);
    int gap;
    if (send_quiet > 0) begin
      send_quiet--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 40) == 0) send_quiet = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    column_sense <= cols;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_traffic(input int budget, input int need);
    int         sent;
    int         pick;
    int         hold_len;
    logic [3:0] pattern;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_tick(4'($urandom_range(0, 15)));
        sent++;
      end else begin
        repeat ($urandom_range(0, 3)) begin
          send_tick(4'hF);
          sent++;
        end
        if ($urandom_range(0, 9) == 0) pattern = 4'($urandom_range(0, 14));
        else pattern = ~(4'b0001 << $urandom_range(0, 3));
        hold_len = (pick < 22) ? $urandom_range(1, need) : need + 1 + $urandom_range(0, 3);
        repeat (hold_len) begin
          send_tick(($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 14)) : pattern);
          sent++;
        end
        send_tick(4'hF);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CfgDebounceTicks;
    cfg_data     = '0;
    in_valid     = 1'b0;
    column_sense = 4'hF;
    send_quiet   = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed presses walk the rows: single keys including the first and
    // last, all columns low, two columns low, and a press that bounces off.
    set_config(10'd1, 10'd1);
    send_tick(4'hF);
    send_tick(4'hE); send_tick(4'hE); send_tick(4'h0); send_tick(4'hF);
    send_tick(4'h7); send_tick(4'h7); send_tick(4'hF);
    send_tick(4'h0); send_tick(4'h0); send_tick(4'hF);
    send_tick(4'h5); send_tick(4'h5); send_tick(4'hF);
    send_tick(4'hB); send_tick(4'hF);
    send_tick(4'hD); send_tick(4'hD); send_tick(4'hF);
    send_tick(4'h7); send_tick(4'h7); send_tick(4'hF);
    send_tick(4'hE); send_tick(4'hE); send_tick(4'hF);
    drain();

    set_config(DebounceReset, DigitHoldReset);
    random_traffic(50, int'(DebounceReset));
    drain();

    set_config(10'd0, 10'd0);
    random_traffic(50, 1);
    drain();

    set_config(10'd1023, 10'd1023);
    repeat ($urandom_range(0, 3)) send_tick(4'hF);
    repeat (1025) send_tick(4'hD);
    send_tick(4'hF);
    drain();

    set_config(10'd2, 10'd7);
    random_traffic(50, 2);
    drain();

    set_config(10'd1, 10'd2);
    random_traffic(50, 1);
    drain();

    repeat (6) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    int gap;
    int taken;
    out_ready  = 1'b0;
    take_quiet = 0;
    taken      = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == 100 || taken == 1200) begin
        gap = 60;
      end else if (take_quiet > 0) begin
        take_quiet--;
        gap = 0;
      end else begin
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 40) == 0) take_quiet = $urandom_range(10, 40);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    #(200_000 * 20);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
